[design/ebl_pkg.sv]
`timescale 1ns / 1ps

package ebl_pkg;

  // Field widths
  localparam int VOL_W     = 8;
  localparam int BLK_W     = 32;
  localparam int TIME_W    = 54;
  localparam int TMO_W     = 16;
  localparam int BSZ_W     = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 19;

  // Item operation codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // One stored entry
  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [BLK_W-1:0]  blk;
    logic [TIME_W-1:0] expiry;
  } entry_t;

endpackage

[design/expiring_block_lookup_table.sv]
`timescale 1ns / 1ps

// Expiring block lookup table.
// Command channel: an item transfers on a rising edge with start high and busy
// low. func selects lookup, add or clear; vol_index, block_num and now_ms are
// the operands. Each item gives one result, shown for one cycle with done
// high: hit, slot, added and fill_count (entries held after the item).
// The receiver cannot stall; a result that is not taken on its cycle is gone.
// Add, clear, unused codes, disabled lookups and lookups on an empty
// table report in the cycle after the transfer and leave busy low, so they
// run one per cycle. An enabled lookup on a non-empty table walks the entry
// memory in append order, one entry per cycle through its single read port,
// until a match or the last entry, and holds busy high until it reports.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 enabled,
// 1 timeout_ms, 2 block size in bytes; cfg_ready is low during a lookup walk.
// Reset: fill count, configuration registers and control state clear to zero; the entry
// memory is not cleared, entries are only read below the fill count.
module expiring_block_lookup_table #(
  parameter int ENTRIES         = 16,
  parameter int MAX_BLOCK_BYTES = 65536,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func,
  input  logic [ebl_pkg::VOL_W-1:0]       vol_index,
  input  logic [ebl_pkg::BLK_W-1:0]       block_num,
  input  logic [ebl_pkg::TIME_W-1:0]      now_ms,
  // result
  output logic                            done,
  output logic                            hit,
  output logic [IDX_W-1:0]                slot,
  output logic                            added,
  output logic [CNT_W-1:0]                fill_count,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ebl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ebl_pkg::CFG_DAT_W-1:0]   cfg_data
);

  // configuration registers
  logic                          enabled;
  logic [ebl_pkg::TMO_W-1:0]     timeout_ms;
  logic [ebl_pkg::BSZ_W-1:0]     blk_bytes;

  ebl_pkg::state_t state, state_next;

  logic [CNT_W-1:0]              count, count_next;
  logic [IDX_W-1:0]              cmp_idx, cmp_next;

  // lookup key held through the walk
  logic [ebl_pkg::VOL_W-1:0]     key_vol;
  logic [ebl_pkg::BLK_W-1:0]     key_blk;
  logic [ebl_pkg::TIME_W-1:0]    key_now;

  // entry memory, one write and one registered read port
  ebl_pkg::entry_t               mem [ENTRIES];
  ebl_pkg::entry_t               rd_data;
  ebl_pkg::entry_t               wr_data;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;

  logic                          accept;
  logic                          scan_go;
  logic                          res_valid;
  logic                          res_hit;
  logic [IDX_W-1:0]              res_slot;
  logic                          res_added;
  logic                          can_add;
  logic                          match;
  logic                          last;
  logic [ebl_pkg::TIME_W:0]      exp_sum;
  logic [ebl_pkg::TIME_W-1:0]    exp_sat;

  assign busy       = (state == ebl_pkg::ST_SCAN);
  assign cfg_ready  = !busy;
  assign accept     = start && !busy;
  assign fill_count = count;

  // expiry = now + timeout, saturating at the top of the time range
  assign exp_sum = {1'b0, now_ms} + {{(ebl_pkg::TIME_W + 1 - ebl_pkg::TMO_W){1'b0}}, timeout_ms};
  assign exp_sat = exp_sum[ebl_pkg::TIME_W] ? {ebl_pkg::TIME_W{1'b1}}
                                            : exp_sum[ebl_pkg::TIME_W-1:0];

  assign can_add = enabled && (blk_bytes <= ebl_pkg::BSZ_W'(MAX_BLOCK_BYTES))
                   && (count < CNT_W'(ENTRIES));

  assign wr_data.vol    = vol_index;
  assign wr_data.blk    = block_num;
  assign wr_data.expiry = exp_sat;

  assign match = (rd_data.vol == key_vol) && (rd_data.blk == key_blk);
  assign last  = (({1'b0, cmp_idx} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(count));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ebl_pkg::ST_IDLE: begin
        if (accept && scan_go) state_next = ebl_pkg::ST_SCAN;
      end
      ebl_pkg::ST_SCAN: begin
        if (res_valid) state_next = ebl_pkg::ST_IDLE;
      end
    endcase
  end

  // item decisions and result values
  always_comb begin
    wr_en      = 1'b0;
    count_next = count;
    res_valid  = 1'b0;
    res_hit    = 1'b0;
    res_slot   = '0;
    res_added  = 1'b0;
    scan_go    = 1'b0;
    cmp_next   = cmp_idx;
    rd_addr    = '0;
    unique case (state)
      ebl_pkg::ST_IDLE: begin
        cmp_next = '0;
        if (accept) begin
          unique case (func)
            ebl_pkg::FUNC_LOOKUP: begin
              // empty table: nothing to walk, count already zero
              if (enabled && (count != '0)) scan_go = 1'b1;
              else res_valid = 1'b1;
            end
            ebl_pkg::FUNC_ADD: begin
              res_valid = 1'b1;
              if (can_add) begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
                res_added  = 1'b1;
              end
            end
            ebl_pkg::FUNC_CLEAR: begin
              res_valid  = 1'b1;
              count_next = '0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ebl_pkg::ST_SCAN: begin
        if (match) begin
          res_valid = 1'b1;
          // expiry equal to now counts as expired
          if (key_now < rd_data.expiry) begin
            res_hit  = 1'b1;
            res_slot = cmp_idx;
          end else begin
            count_next = '0;
          end
        end else if (last) begin
          res_valid  = 1'b1;
          count_next = '0;
        end else begin
          cmp_next = cmp_idx + IDX_W'(1);
          rd_addr  = cmp_idx + IDX_W'(1);
        end
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IDX_W-1:0]] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ebl_pkg::ST_IDLE;
      count      <= '0;
      cmp_idx    <= '0;
      done       <= 1'b0;
      enabled    <= 1'b0;
      timeout_ms <= '0;
      blk_bytes  <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_idx <= cmp_next;
      done    <= res_valid;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ebl_pkg::CFG_ENABLED:   enabled    <= cfg_data[0];
          ebl_pkg::CFG_TIMEOUT:   timeout_ms <= cfg_data[ebl_pkg::TMO_W-1:0];
          ebl_pkg::CFG_BLK_BYTES: blk_bytes  <= cfg_data[ebl_pkg::BSZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload and lookup key
  always_ff @(posedge clk) begin
    hit   <= res_hit;
    slot  <= res_slot;
    added <= res_added;
    if (accept) begin
      key_vol <= vol_index;
      key_blk <= block_num;
      key_now <= now_ms;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("fill count beyond table depth");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    accept && (func == ebl_pkg::FUNC_LOOKUP) && enabled && (count != '0) |=> busy)
    else $error("lookup on filled table did not start a walk");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("walk ended without a result");

  a_hit_slot: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> ({1'b0, slot} < (IDX_W + 1)'(fill_count)) && !added)
    else $error("hit slot outside the filled entries");
`endif

endmodule
